FILE: src/cltl_pkg.sv
`default_nettype none
package cltl_pkg;
    localparam int COUNT_BITS = 24;
    localparam int OUT_BITS = 24;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [3:0] M_IDLE = 4'd0;
    localparam logic [3:0] M_IDENT = 4'd1;
    localparam logic [3:0] M_INT = 4'd2;
    localparam logic [3:0] M_INT_DOT = 4'd3;
    localparam logic [3:0] M_FLOAT = 4'd4;
    localparam logic [3:0] M_OP = 4'd5;
    localparam logic [3:0] M_SLASH = 4'd6;
    localparam logic [3:0] M_LINE = 4'd7;
    localparam logic [3:0] M_BLOCK = 4'd8;
    localparam logic [3:0] M_BLOCK_STAR = 4'd9;

    localparam logic [2:0] K_IDENT = 3'd0;
    localparam logic [2:0] K_KEYWORD = 3'd1;
    localparam logic [2:0] K_INT = 3'd2;
    localparam logic [2:0] K_FLOAT = 3'd3;
    localparam logic [2:0] K_OPER = 3'd4;
    localparam logic [2:0] K_DELIM = 3'd5;
    localparam logic [2:0] K_SUMMARY = 3'd6;

    localparam logic [3:0] OP_SLASH = 4'd9;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] sub;
        logic [OUT_BITS-1:0] line;
        logic [OUT_BITS-1:0] column;
        logic [OUT_BITS-1:0] offset;
        logic [OUT_BITS-1:0] length;
        logic unterm;
        logic [OUT_BITS-1:0] bad;
        logic last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t r0;
        result_t r1;
    } result_set_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction
endpackage
`default_nettype wire

FILE: src/cltl_step.sv
`default_nettype none
module cltl_step (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         step_en,
    input  wire logic [7:0]                   ch,
    input  wire logic                         eoi,
    output cltl_pkg::result_set_t             res
);
    import cltl_pkg::*;

    logic [3:0] mode_reg, mode_next;
    logic [47:0] word_reg, word_next;
    logic [7:0] held_reg, held_next;
    logic [COUNT_BITS-1:0] line_reg, line_next, col_reg, col_next, off_reg, off_next;
    logic [COUNT_BITS-1:0] tline_reg, tline_next, tcol_reg, tcol_next;
    logic [COUNT_BITS-1:0] toff_reg, toff_next, tlen_reg, tlen_next;
    logic [COUNT_BITS-1:0] bad_reg, bad_next;
    logic cerr_reg, cerr_next;

    // token record as it stands after the first (pending) emission
    logic [1:0] n;
    result_t r0, r1;

    function automatic result_t mk(input logic [2:0] k, input logic [3:0] s,
                                   input logic [COUNT_BITS-1:0] ln,
                                   input logic [COUNT_BITS-1:0] cl,
                                   input logic [COUNT_BITS-1:0] of,
                                   input logic [COUNT_BITS-1:0] le,
                                   input logic [COUNT_BITS-1:0] bd);
        result_t r;
        r.kind = k;
        r.sub = s;
        r.line = ln[OUT_BITS-1:0];
        r.column = cl[OUT_BITS-1:0];
        r.offset = of[OUT_BITS-1:0];
        r.length = le[OUT_BITS-1:0];
        r.unterm = 1'b0;
        r.bad = bd[OUT_BITS-1:0];
        r.last = 1'b0;
        return r;
    endfunction

    function automatic logic [3:0] kw_index(input logic [47:0] w,
                                            input logic [COUNT_BITS-1:0] len,
                                            output logic hit);
        hit = 1'b1;
        if (len == 3 && w == 48'h696E74) return 4'd0;
        if (len == 5 && w == 48'h666C6F6174) return 4'd1;
        if (len == 4 && w == 48'h766F6964) return 4'd2;
        if (len == 2 && w == 48'h6966) return 4'd3;
        if (len == 4 && w == 48'h656C7365) return 4'd4;
        if (len == 5 && w == 48'h7768696C65) return 4'd5;
        if (len == 6 && w == 48'h72657475726E) return 4'd6;
        if (len == 5 && w == 48'h636F6E7374) return 4'd7;
        hit = 1'b0;
        return 4'd0;
    endfunction

    always_comb begin
        logic emit;
        logic [2:0] ek;
        logic [3:0] es;
        logic go_idle;
        logic hit;
        logic [3:0] kwi;
        logic [7:0] c;
        logic [COUNT_BITS-1:0] bad_mid;
        logic [COUNT_BITS-1:0] sl, sc, so, len_s;
        logic emit2;
        logic [2:0] k2;
        logic [3:0] s2;
        logic start;

        c = ch;
        mode_next = mode_reg;
        word_next = word_reg;
        held_next = held_reg;
        line_next = line_reg;
        col_next = col_reg;
        off_next = off_reg;
        tline_next = tline_reg;
        tcol_next = tcol_reg;
        toff_next = toff_reg;
        tlen_next = tlen_reg;
        bad_next = bad_reg;
        cerr_next = cerr_reg;
        emit = 1'b0;
        ek = K_IDENT;
        es = 4'd0;
        go_idle = 1'b0;
        kwi = kw_index(word_reg, tlen_reg, hit);
        emit2 = 1'b0;
        k2 = K_IDENT;
        s2 = 4'd0;
        start = 1'b0;
        sl = line_reg;
        sc = col_reg;
        so = off_reg;
        len_s = COUNT_BITS'(1);
        n = 2'd0;
        r0 = '0;
        r1 = '0;

        // first stage: pending token resolution (flush or terminated by c)
        unique case (mode_reg)
            M_IDENT: begin
                if (!eoi && (is_letter(c) || is_digit(c))) begin
                    if (tlen_reg < 6) word_next = {word_reg[39:0], c};
                    tlen_next = sat_inc(tlen_reg);
                end else begin
                    emit = 1'b1;
                    ek = hit ? K_KEYWORD : K_IDENT;
                    es = hit ? kwi : 4'd0;
                    go_idle = 1'b1;
                end
            end
            M_INT: begin
                if (!eoi && is_digit(c)) tlen_next = sat_inc(tlen_reg);
                else if (!eoi && c == ".") mode_next = M_INT_DOT;
                else begin
                    emit = 1'b1;
                    ek = K_INT;
                    go_idle = 1'b1;
                end
            end
            M_INT_DOT: begin
                if (!eoi && is_digit(c)) begin
                    tlen_next = sat_inc(sat_inc(tlen_reg));
                    mode_next = M_FLOAT;
                end else begin
                    emit = 1'b1;
                    ek = K_INT;
                    go_idle = 1'b1;
                    bad_next = sat_inc(bad_reg);
                end
            end
            M_FLOAT: begin
                if (!eoi && is_digit(c)) tlen_next = sat_inc(tlen_reg);
                else begin
                    emit = 1'b1;
                    ek = K_FLOAT;
                    go_idle = 1'b1;
                end
            end
            M_OP: begin
                logic pair;
                logic [3:0] pc;
                pair = 1'b0;
                pc = 4'd0;
                if (!eoi && c == "=") begin
                    pair = 1'b1;
                    case (held_reg)
                        "=": pc = 4'd0;
                        "<": pc = 4'd1;
                        ">": pc = 4'd2;
                        "!": pc = 4'd3;
                        default: pair = 1'b0;
                    endcase
                end else if (!eoi && c == "&" && held_reg == "&") begin
                    pair = 1'b1;
                    pc = 4'd4;
                end else if (!eoi && c == "|" && held_reg == "|") begin
                    pair = 1'b1;
                    pc = 4'd5;
                end
                if (pair) begin
                    tlen_next = COUNT_BITS'(2);
                    emit = 1'b1;
                    ek = K_OPER;
                    es = pc;
                    mode_next = M_IDLE;
                end else begin
                    go_idle = 1'b1;
                    emit = 1'b1;
                    ek = K_OPER;
                    case (held_reg)
                        "=": es = 4'd11;
                        "<": es = 4'd12;
                        ">": es = 4'd13;
                        "!": es = 4'd14;
                        default: begin
                            emit = 1'b0;
                            bad_next = sat_inc(bad_reg);
                        end
                    endcase
                end
            end
            M_SLASH: begin
                if (!eoi && c == "/") mode_next = M_LINE;
                else if (!eoi && c == "*") mode_next = M_BLOCK;
                else begin
                    emit = 1'b1;
                    ek = K_OPER;
                    es = OP_SLASH;
                    go_idle = 1'b1;
                end
            end
            M_LINE: begin
                if (eoi) mode_next = M_IDLE;
                else if (c == "\n") mode_next = M_IDLE;
            end
            M_BLOCK: begin
                if (eoi) cerr_next = 1'b1;
                else if (c == "*") mode_next = M_BLOCK_STAR;
            end
            M_BLOCK_STAR: begin
                if (eoi) cerr_next = 1'b1;
                else if (c == "/") mode_next = M_IDLE;
                else if (c != "*") mode_next = M_BLOCK;
            end
            default: go_idle = 1'b1;
        endcase

        // tlen_next holds 2 for a paired op; the emit uses it
        if (emit) begin
            r0 = mk(ek, es, tline_reg, tcol_reg, toff_reg,
                    (mode_reg == M_OP && !go_idle) ? tlen_next : tlen_reg, bad_reg);
            n = 2'd1;
        end
        bad_mid = bad_next;

        if (eoi) begin
            result_t s;
            s.kind = K_SUMMARY;
            s.sub = 4'd0;
            s.line = line_reg[OUT_BITS-1:0];
            s.column = col_reg[OUT_BITS-1:0];
            s.offset = off_reg[OUT_BITS-1:0];
            s.length = '0;
            s.unterm = cerr_next;
            s.bad = bad_mid[OUT_BITS-1:0];
            s.last = 1'b1;
            if (emit) r1 = s;
            else r0 = s;
            n = emit ? 2'd2 : 2'd1;
            mode_next = M_IDLE;
            word_next = '0;
            held_next = '0;
            line_next = COUNT_BITS'(1);
            col_next = COUNT_BITS'(1);
            off_next = '0;
            tline_next = '0;
            tcol_next = '0;
            toff_next = '0;
            tlen_next = '0;
            bad_next = '0;
            cerr_next = 1'b0;
        end else begin
            if (go_idle) begin
                mode_next = M_IDLE;
                if (is_letter(c)) begin
                    start = 1'b1;
                    word_next = {40'd0, c};
                    mode_next = M_IDENT;
                end else if (is_digit(c)) begin
                    start = 1'b1;
                    mode_next = M_INT;
                end else if (c == " " || c == "\t" || c == 8'h0d || c == "\n") begin
                end else if (c == "/") begin
                    start = 1'b1;
                    mode_next = M_SLASH;
                end else if (c == "=" || c == "<" || c == ">" || c == "!" ||
                             c == "&" || c == "|") begin
                    start = 1'b1;
                    held_next = c;
                    mode_next = M_OP;
                end else if (c == "+" || c == "-" || c == "*" || c == "%") begin
                    start = 1'b1;
                    emit2 = 1'b1;
                    k2 = K_OPER;
                    s2 = (c == "+") ? 4'd6 : (c == "-") ? 4'd7 : (c == "*") ? 4'd8 : 4'd10;
                end else begin
                    case (c)
                        "(": begin start = 1'b1; emit2 = 1'b1; k2 = K_DELIM; s2 = 4'd0; end
                        ")": begin start = 1'b1; emit2 = 1'b1; k2 = K_DELIM; s2 = 4'd1; end
                        "{": begin start = 1'b1; emit2 = 1'b1; k2 = K_DELIM; s2 = 4'd2; end
                        "}": begin start = 1'b1; emit2 = 1'b1; k2 = K_DELIM; s2 = 4'd3; end
                        ";": begin start = 1'b1; emit2 = 1'b1; k2 = K_DELIM; s2 = 4'd4; end
                        ",": begin start = 1'b1; emit2 = 1'b1; k2 = K_DELIM; s2 = 4'd5; end
                        default: bad_next = sat_inc(bad_mid);
                    endcase
                end
                if (start) begin
                    tline_next = sl;
                    tcol_next = sc;
                    toff_next = so;
                    tlen_next = len_s;
                end
                if (emit2) begin
                    if (emit) r1 = mk(k2, s2, sl, sc, so, len_s, bad_mid);
                    else r0 = mk(k2, s2, sl, sc, so, len_s, bad_mid);
                    n = emit ? 2'd2 : 2'd1;
                end
            end
            off_next = sat_inc(off_reg);
            if (c == "\n") begin
                line_next = sat_inc(line_reg);
                col_next = COUNT_BITS'(1);
            end else begin
                col_next = sat_inc(col_reg);
            end
        end
    end

    assign res.count = n;
    assign res.r0 = r0;
    assign res.r1 = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            word_reg <= '0;
            held_reg <= '0;
            line_reg <= COUNT_BITS'(1);
            col_reg <= COUNT_BITS'(1);
            off_reg <= '0;
            tline_reg <= '0;
            tcol_reg <= '0;
            toff_reg <= '0;
            tlen_reg <= '0;
            bad_reg <= '0;
            cerr_reg <= 1'b0;
        end else if (step_en) begin
            mode_reg <= mode_next;
            word_reg <= word_next;
            held_reg <= held_next;
            line_reg <= line_next;
            col_reg <= col_next;
            off_reg <= off_next;
            tline_reg <= tline_next;
            tcol_reg <= tcol_next;
            toff_reg <= toff_next;
            tlen_reg <= tlen_next;
            bad_reg <= bad_next;
            cerr_reg <= cerr_next;
        end
    end
endmodule
`default_nettype wire

FILE: src/cltl_outq.sv
`default_nettype none
module cltl_outq (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  cltl_pkg::result_set_t      in_set,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output cltl_pkg::result_t          out_res
);
    import cltl_pkg::*;

    // four-entry result queue; an item adds at most two results
    result_t q_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;
    logic pop;
    logic [1:0] push_n;

    assign out_valid = cnt_reg != 3'd0;
    assign out_res = q_reg[rd_reg];
    assign pop = out_valid && out_ready;
    assign in_ready = cnt_reg <= 3'd2;
    assign push_n = (in_valid && in_ready) ? in_set.count : 2'd0;

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) q_reg[wr_reg] <= in_set.r0;
        if (push_n == 2'd2) q_reg[wr_reg + 2'd1] <= in_set.r1;
        if (!aresetn) begin
            rd_reg <= '0;
            wr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg <= wr_reg + push_n;
            rd_reg <= rd_reg + {1'b0, pop};
            cnt_reg <= cnt_reg + {1'b0, push_n} - {2'b0, pop};
        end
    end
endmodule
`default_nettype wire

FILE: src/c_like_token_lexer_unit.sv
`default_nettype none
// Streaming lexer: one source byte per transfer on the s_ channel, tokens on m_.
// s_end_of_input=1 flushes the pending token and emits a summary (is_last=1),
// then all positions and counters return to their start values.
// Each input transfer is resolved in the cycle it is accepted: the scanner
// state updates at that edge and its zero to two results enter a four-entry
// result queue; m_ shows the head of that registered queue. With m_ready
// high, one byte per cycle is sustained while bytes average at most one
// result; a byte that closes a token and is itself a one-byte token adds
// two, and m_ drains one per cycle, so runs of those halve the input rate.
// When the receiver stalls, the queue fills and s_ready drops once fewer
// than two entries are free.
// Reset (aresetn low, synchronous) empties the queue and sets line and
// column to 1, offsets and counts to 0, and the scanner to idle.
module c_like_token_lexer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_ch,
    input  wire logic        s_end_of_input,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_event_kind,
    output logic [3:0]       m_sub_code,
    output logic [23:0]      m_start_line,
    output logic [23:0]      m_start_column,
    output logic [23:0]      m_start_offset,
    output logic [23:0]      m_token_length,
    output logic             m_unterminated_comment,
    output logic [23:0]      m_unsupported_total,
    output logic             m_is_last
);
    import cltl_pkg::*;

    result_set_t set;
    result_t res;
    logic acc;

    assign acc = s_valid && s_ready;

    cltl_step u_step (
        .aclk(aclk), .aresetn(aresetn), .step_en(acc),
        .ch(s_ch), .eoi(s_end_of_input), .res(set)
    );

    cltl_outq u_q (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_set(set),
        .out_valid(m_valid), .out_ready(m_ready), .out_res(res)
    );

    assign m_event_kind = res.kind;
    assign m_sub_code = res.sub;
    assign m_start_line = res.line;
    assign m_start_column = res.column;
    assign m_start_offset = res.offset;
    assign m_token_length = res.length;
    assign m_unterminated_comment = res.unterm;
    assign m_unsupported_total = res.bad;
    assign m_is_last = res.last;
endmodule
`default_nettype wire
